@@ design/ht2_pkg.sv @@
// Shared types, constants and filter functions of the Hitag2 stream cipher.
package ht2_pkg;

    // Widths of the cipher state and fields.
    localparam int unsigned LFSR_W   = 48;
    localparam int unsigned KEY_LO_W = 16;
    localparam int unsigned SER_W    = 32;
    localparam int unsigned IV_W     = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CNT_W    = 4;

    // Full byte of keystream bits.
    localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;

    // Init runs one shift step per IV bit.
    localparam logic [4:0] INIT_LAST_STEP = 5'd31;

    // Authenticate emits four bytes.
    localparam logic [1:0] AUTH_LAST_BYTE = 2'd3;

    // Nonlinear filter tables.
    localparam logic [15:0] TAB_A = 16'h2C79;
    localparam logic [15:0] TAB_B = 16'h6671;
    localparam logic [31:0] TAB_C = 32'h7907287B;

    // Feedback taps: bits 0,2,3,6,7,8,16,22,23,26,30,41,42,43,46,47.
    localparam logic [LFSR_W-1:0] FB_MASK = 48'hCE00_44C1_01CD;

    // Configuration register indexes.
    localparam logic REG_KEY    = 1'b0;
    localparam logic REG_SERIAL = 1'b1;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_AUTH   = 2'd1,
        OP_XCRYPT = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROUND,
        ST_EMIT
    } state_t;

    // Selection of the emitted byte.
    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_INV,
        OUT_PLAIN
    } out_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_init;
        logic     load_data;
        logic     clear_work;
        logic     init_step;
        logic     round_step;
        logic [2:0] bit_idx;
        logic     emit;
        out_sel_t out_sel;
        logic     last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } status_t;

    // Nonlinear 20-input filter on a state word.
    function automatic logic filter20(input logic [LFSR_W-1:0] s);
        logic [4:0] sel;
        sel[0] = TAB_A[{s[5],  s[4],  s[2],  s[1]}];
        sel[1] = TAB_B[{s[14], s[13], s[11], s[7]}];
        sel[2] = TAB_B[{s[25], s[22], s[20], s[16]}];
        sel[3] = TAB_B[{s[32], s[30], s[28], s[27]}];
        sel[4] = TAB_A[{s[45], s[43], s[42], s[33]}];
        return TAB_C[sel];
    endfunction

    // Linear feedback bit of a state word.
    function automatic logic feedback(input logic [LFSR_W-1:0] s);
        return ^(s & FB_MASK);
    endfunction

endpackage

@@ design/ht2_datapath.sv @@
// Datapath of the Hitag2 cipher: key registers, LFSR, work byte and output register.
module ht2_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [ht2_pkg::LFSR_W-1:0]     cfg_data,
    input  logic [ht2_pkg::IV_W-1:0]       iv,
    input  logic [ht2_pkg::BYTE_W-1:0]     data_in,
    input  ht2_pkg::cmd_t                  cmd,
    output ht2_pkg::status_t               status,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ht2_pkg::BYTE_W-1:0]     data_out,
    output logic                           last
);

    logic [ht2_pkg::LFSR_W-1:0] key_reg;
    logic [ht2_pkg::SER_W-1:0]  serial_reg;
    logic [ht2_pkg::LFSR_W-1:0] lfsr_reg;
    logic [ht2_pkg::LFSR_W-1:0] lfsr_next;
    logic [ht2_pkg::IV_W-1:0]   ivk_reg;
    logic [ht2_pkg::IV_W-1:0]   ivk_next;
    logic [ht2_pkg::BYTE_W-1:0] work_reg;
    logic [ht2_pkg::BYTE_W-1:0] work_next;
    logic [ht2_pkg::BYTE_W-1:0] data_out_reg;
    logic [ht2_pkg::BYTE_W-1:0] data_out_next;
    logic                       last_reg;
    logic                       out_valid_reg;
    logic [ht2_pkg::LFSR_W-1:0] init_shift;
    logic [ht2_pkg::LFSR_W-1:0] round_state;
    logic                       keystream_bit;
    logic [2:0]                 bit_pos;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            serial_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ht2_pkg::REG_KEY:    key_reg    <= cfg_data;
                ht2_pkg::REG_SERIAL: serial_reg <= cfg_data[ht2_pkg::SER_W-1:0];
                default:             key_reg    <= key_reg;
            endcase
        end
    end

    // One init step and one keystream round, both computed from the current state.
    always_comb
    begin
        init_shift    = {1'b0, lfsr_reg[ht2_pkg::LFSR_W-1:1]};
        round_state   = {ht2_pkg::feedback(lfsr_reg), lfsr_reg[ht2_pkg::LFSR_W-1:1]};
        keystream_bit = ht2_pkg::filter20(round_state);
        bit_pos       = 3'd7 - cmd.bit_idx;
    end

    // Next values of the LFSR, the IV/key shift register and the work byte.
    always_comb
    begin
        lfsr_next = lfsr_reg;
        ivk_next  = ivk_reg;
        work_next = work_reg;
        if (cmd.load_init)
        begin
            lfsr_next = {key_reg[ht2_pkg::KEY_LO_W-1:0], serial_reg};
            ivk_next  = iv ^ key_reg[ht2_pkg::LFSR_W-1:ht2_pkg::KEY_LO_W];
        end
        else if (cmd.init_step)
        begin
            lfsr_next = {ht2_pkg::filter20(init_shift) ^ ivk_reg[0],
                         init_shift[ht2_pkg::LFSR_W-2:0]};
            ivk_next  = {1'b0, ivk_reg[ht2_pkg::IV_W-1:1]};
        end
        else if (cmd.round_step)
        begin
            lfsr_next          = round_state;
            work_next[bit_pos] = work_reg[bit_pos] ^ keystream_bit;
        end
        if (cmd.load_data)
        begin
            work_next = data_in;
        end
        else if (cmd.clear_work)
        begin
            work_next = '0;
        end
    end

    // Cipher state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= '0;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

    // Payload registers of the datapath.
    always_ff @(posedge clk)
    begin
        ivk_reg  <= ivk_next;
        work_reg <= work_next;
    end

    // Byte chosen for the result.
    always_comb
    begin
        unique case (cmd.out_sel)
            ht2_pkg::OUT_INV:   data_out_next = ~work_reg;
            ht2_pkg::OUT_PLAIN: data_out_next = work_reg;
            default:            data_out_next = '0;
        endcase
    end

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            data_out_reg <= data_out_next;
            last_reg     <= cmd.last;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign data_out        = data_out_reg;
    assign last            = last_reg;

endmodule

@@ design/ht2_ctrl.sv @@
// Controller state machine of the Hitag2 cipher: sequences init, rounds and results.
module ht2_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  operation,
    input  logic [ht2_pkg::CNT_W-1:0]   bit_count,
    input  ht2_pkg::status_t            status,
    output ht2_pkg::cmd_t               cmd
);

    ht2_pkg::state_t             state_reg;
    ht2_pkg::state_t             state_next;
    ht2_pkg::op_t                op_reg;
    ht2_pkg::op_t                op_next;
    logic [4:0]                  step_reg;
    logic [4:0]                  step_next;
    logic [ht2_pkg::CNT_W-1:0]   bits_reg;
    logic [ht2_pkg::CNT_W-1:0]   bits_next;
    logic [1:0]                  byte_reg;
    logic [1:0]                  byte_next;
    logic [ht2_pkg::CNT_W-1:0]   count_clamped;
    logic                        accept;
    ht2_pkg::op_t                in_op;

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ht2_pkg::ST_IDLE;
            op_reg    <= ht2_pkg::OP_NONE;
            step_reg  <= '0;
            bits_reg  <= '0;
            byte_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            step_reg  <= step_next;
            bits_reg  <= bits_next;
            byte_reg  <= byte_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        in_op         = ht2_pkg::op_t'(operation);
        count_clamped = (bit_count > ht2_pkg::BITS_PER_BYTE) ? ht2_pkg::BITS_PER_BYTE
                                                             : bit_count;
        in_stall      = (state_reg != ht2_pkg::ST_IDLE);
        accept        = in_valid && !in_stall;

        state_next = state_reg;
        op_next    = op_reg;
        step_next  = step_reg;
        bits_next  = bits_reg;
        byte_next  = byte_reg;

        cmd            = '0;
        cmd.bit_idx    = step_reg[2:0];
        cmd.out_sel    = ht2_pkg::OUT_ZERO;

        unique case (state_reg)
            ht2_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = in_op;
                    step_next = '0;
                    byte_next = '0;
                    unique case (in_op)
                        ht2_pkg::OP_INIT:
                        begin
                            cmd.load_init = 1'b1;
                            state_next    = ht2_pkg::ST_INIT;
                        end
                        ht2_pkg::OP_AUTH:
                        begin
                            cmd.clear_work = 1'b1;
                            bits_next      = ht2_pkg::BITS_PER_BYTE;
                            state_next     = ht2_pkg::ST_ROUND;
                        end
                        ht2_pkg::OP_XCRYPT:
                        begin
                            cmd.load_data = 1'b1;
                            bits_next     = count_clamped;
                            state_next    = (count_clamped == '0) ? ht2_pkg::ST_EMIT
                                                                  : ht2_pkg::ST_ROUND;
                        end
                        default:
                        begin
                            state_next = ht2_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            ht2_pkg::ST_INIT:
            begin
                cmd.init_step = 1'b1;
                step_next     = step_reg + 5'd1;
                if (step_reg == ht2_pkg::INIT_LAST_STEP)
                begin
                    state_next = ht2_pkg::ST_EMIT;
                end
            end

            ht2_pkg::ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                step_next      = step_reg + 5'd1;
                if ((step_reg[ht2_pkg::CNT_W-1:0] + 4'd1) == bits_reg)
                begin
                    state_next = ht2_pkg::ST_EMIT;
                end
            end

            ht2_pkg::ST_EMIT:
            begin
                unique case (op_reg)
                    ht2_pkg::OP_AUTH:   cmd.out_sel = ht2_pkg::OUT_INV;
                    ht2_pkg::OP_XCRYPT: cmd.out_sel = ht2_pkg::OUT_PLAIN;
                    default:            cmd.out_sel = ht2_pkg::OUT_ZERO;
                endcase
                cmd.last = !(op_reg == ht2_pkg::OP_AUTH && byte_reg != ht2_pkg::AUTH_LAST_BYTE);
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!cmd.last)
                    begin
                        // Next authenticator byte starts from a cleared byte.
                        cmd.clear_work = 1'b1;
                        byte_next      = byte_reg + 2'd1;
                        step_next      = '0;
                        state_next     = ht2_pkg::ST_ROUND;
                    end
                    else
                    begin
                        state_next = ht2_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ht2_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/hitag2_stream_cipher.sv @@
// Top level of the Hitag2 stream cipher: controller and datapath.
//
// The block runs one LFSR round per clock and works on one item at a time;
// in_stall is high from the transfer of an item until its last result is in
// the output register. Init runs one shift step per IV bit and then loads its
// result. Transcrypt runs one round per applied bit, 0 to 8 bits (a larger
// bit_count is clamped to 8), then loads its result. Authenticate produces
// four bytes of eight keystream bits. Each result needs the output register
// free, so a stalled output holds the block back.
// Operation code 3 is taken and dropped without a result or a state change.
// key_value (index 0) and serial_number (index 1) are read only by init; the user
// must write them only while the block is idle, which the block does not enforce.
module hitag2_stream_cipher (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [ht2_pkg::LFSR_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     operation,
    input  logic [ht2_pkg::IV_W-1:0]       iv,
    input  logic [ht2_pkg::BYTE_W-1:0]     data_in,
    input  logic [ht2_pkg::CNT_W-1:0]      bit_count,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ht2_pkg::BYTE_W-1:0]     data_out,
    output logic                           last
);

    ht2_pkg::cmd_t    cmd;
    ht2_pkg::status_t status;

    // Sequencing of init, rounds and result transfers.
    ht2_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .bit_count (bit_count),
        .status    (status),
        .cmd       (cmd)
    );

    // Key registers, LFSR and output register.
    ht2_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .iv        (iv),
        .data_in   (data_in),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .last      (last)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the Hitag2 stream cipher block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ht2_pkg::*;

    localparam int IDLE_GUARD  = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 60;
    localparam int PHASE_ITEMS = 24;
    localparam int NUM_PHASES  = 5;
    localparam int NUM_ROWS    = 22;

    // One directed item, with an optional register load before it.
    typedef struct packed {
        logic        load_cfg;
        logic [47:0] key;
        logic [31:0] serial;
        op_t         op;
        logic [31:0] iv;
        logic [7:0]  din;
        logic [3:0]  cnt;
        logic        fixed;
        logic [7:0]  want;
    } stim_row_t;

    // One expected output byte.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_byte_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [LFSR_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           operation;
    logic [IV_W-1:0]      iv;
    logic [BYTE_W-1:0]    data_in;
    logic [CNT_W-1:0]     bit_count;
    logic                 out_valid;
    logic                 out_stall;
    logic [BYTE_W-1:0]    data_out;
    logic                 last;

    // Predictor copy of the cipher registers and state.
    logic [47:0] model_key;
    logic [31:0] model_serial;
    logic [47:0] model_lfsr;

    out_byte_t   pending_bytes[$];
    stim_row_t   directed_rows [0:NUM_ROWS-1];

    int  mismatch_count;
    int  result_count;
    int  init_count;
    int  auth_count;
    int  xcrypt_count;
    int  ignored_count;
    int  cfg_writes;
    int  next_gap;
    bit  quiet;
    bit  hold_req;

    hitag2_stream_cipher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .iv        (iv),
        .data_in   (data_in),
        .bit_count (bit_count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .last      (last)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #5ms;
        $display("hitag2_stream_cipher test failed");
        $finish;
    end

    // Nonlinear filter: five lookups in two 4-input tables feed the 5-input table.
    function automatic logic ks_filter(input logic [47:0] s);
        logic [4:0] sel;
        sel[0] = TAB_A[{s[5], s[4], s[2], s[1]}];
        sel[1] = TAB_B[{s[14], s[13], s[11], s[7]}];
        sel[2] = TAB_B[{s[25], s[22], s[20], s[16]}];
        sel[3] = TAB_B[{s[32], s[30], s[28], s[27]}];
        sel[4] = TAB_A[{s[45], s[43], s[42], s[33]}];
        return TAB_C[sel];
    endfunction

    // One LFSR round: shift right with the tap parity entering at the top.
    function automatic logic [47:0] lfsr_advance(input logic [47:0] s);
        logic fb;
        fb = s[0] ^ s[2] ^ s[3] ^ s[6] ^ s[7] ^ s[8] ^ s[16] ^ s[22] ^ s[23]
           ^ s[26] ^ s[30] ^ s[41] ^ s[42] ^ s[43] ^ s[46] ^ s[47];
        return {fb, s[47:1]};
    endfunction

    // Work out the output bytes of one accepted item and queue them.
    task automatic predict_item(input op_t op, input logic [31:0] seed,
                                input logic [7:0] din, input logic [3:0] cnt,
                                input logic fixed, input logic [7:0] want);
        logic [47:0] x;
        logic [7:0]  ks;
        logic [7:0]  d;
        int          first;
        int          n;
        first = pending_bytes.size();
        case (op)
            OP_INIT:
            begin
                x = {model_key[15:0], model_serial};
                for (int i = 0; i < 32; i++)
                begin
                    x = x >> 1;
                    x[47] = ks_filter(x) ^ seed[i] ^ model_key[i + 16];
                end
                model_lfsr = x;
                pending_bytes.push_back('{8'h00, 1'b1});
                init_count++;
            end
            OP_AUTH:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        model_lfsr = lfsr_advance(model_lfsr);
                        ks[7 - i] = ks_filter(model_lfsr);
                    end
                    pending_bytes.push_back('{~ks, k == 3});
                end
                auth_count++;
            end
            OP_XCRYPT:
            begin
                n = (cnt > BITS_PER_BYTE) ? 8 : int'(cnt);
                d = din;
                for (int i = 0; i < n; i++)
                begin
                    model_lfsr = lfsr_advance(model_lfsr);
                    d[7 - i] = d[7 - i] ^ ks_filter(model_lfsr);
                end
                pending_bytes.push_back('{d, 1'b1});
                xcrypt_count++;
            end
            default:
            begin
                ignored_count++;
            end
        endcase
        // Rows with a hand-written answer check against that value instead.
        if (fixed)
        begin
            for (int j = first; j < pending_bytes.size(); j++)
            begin
                pending_bytes[j].data = want;
            end
        end
    endtask

    // Offer one item, hold it until the transfer, then queue its results.
    task automatic send_item(input op_t op, input logic [31:0] seed,
                             input logic [7:0] din, input logic [3:0] cnt,
                             input logic fixed, input logic [7:0] want);
        repeat (next_gap) @(negedge clk);
        operation = op;
        iv        = seed;
        data_in   = din;
        bit_count = cnt;
        in_valid  = 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_item(op, seed, din, cnt, fixed, want);
        @(negedge clk);
        next_gap = quiet ? 0 : $urandom_range(0, 14);
        if (next_gap != 0)
        begin
            in_valid = 1'b0;
        end
    endtask

    // Stop offering and wait until every queued byte has arrived.
    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_bytes.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Load both registers once the block has gone quiet.
    task automatic load_registers(input logic [47:0] key, input logic [31:0] serial);
        drain_results();
        // A dropped item may still be in flight after the last byte.
        repeat (IDLE_GUARD) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = REG_KEY;
        cfg_data  = key;
        @(negedge clk);
        // Upper bits of the serial write are junk and must be masked off.
        cfg_index = REG_SERIAL;
        cfg_data  = {16'($urandom), serial};
        @(negedge clk);
        cfg_we    = 1'b0;
        model_key    = key;
        model_serial = serial;
        cfg_writes += 2;
    endtask

    // Random item, weighted toward keystream traffic after an init.
    task automatic send_random();
        int          r;
        op_t         op;
        logic [3:0]  cnt;
        r = $urandom_range(0, 99);
        if (r < 12)
            op = OP_INIT;
        else if (r < 35)
            op = OP_AUTH;
        else if (r < 92)
            op = OP_XCRYPT;
        else
            op = OP_NONE;
        cnt = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : BITS_PER_BYTE;
        send_item(op, $urandom, 8'($urandom_range(0, 255)), cnt, 1'b0, 8'h00);
    endtask

    // Receiver: random stalls per byte, plus one long hold on request.
    initial
    begin : rx_side
        int w;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = quiet ? 0 : $urandom_range(0, 14);
            if (hold_req)
            begin
                w = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (w > 0)
            begin
                out_stall = 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // Compare every output transfer with the oldest expected byte.
    always @(posedge clk)
    begin
        out_byte_t exp_byte;
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (pending_bytes.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected byte data_out=%02h last=%0b",
                         $realtime, data_out, last);
            end
            else
            begin
                exp_byte = pending_bytes.pop_front();
                if (data_out !== exp_byte.data)
                begin
                    mismatch_count++;
                    $display("%0t: data_out expected %02h actual %02h",
                             $realtime, exp_byte.data, data_out);
                end
                if (last !== exp_byte.last)
                begin
                    mismatch_count++;
                    $display("%0t: last expected %0b actual %0b",
                             $realtime, exp_byte.last, last);
                end
            end
        end
    end

    // Reset, directed rows, random phases, then the verdict.
    initial
    begin : stimulus
        stim_row_t row;
        int        taken;
        logic [47:0] pk;
        logic [31:0] ps;

        mismatch_count = 0;
        result_count   = 0;
        init_count     = 0;
        auth_count     = 0;
        xcrypt_count   = 0;
        ignored_count  = 0;
        cfg_writes     = 0;
        next_gap       = 0;
        quiet          = 1'b0;
        hold_req       = 1'b0;
        model_key      = '0;
        model_serial   = '0;
        model_lfsr     = '0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_KEY;
        cfg_data  = '0;
        in_valid  = 1'b0;
        operation = OP_NONE;
        iv        = '0;
        data_in   = '0;
        bit_count = '0;

        // Zero state gives a zero keystream, so the first rows are known outright.
        directed_rows = '{
            '{1'b0, 48'h0, 32'h0, OP_AUTH,   32'h0000_0000, 8'h00, 4'd8,  1'b1, 8'hFF},
            '{1'b0, 48'h0, 32'h0, OP_XCRYPT, 32'h0000_0000, 8'hA5, 4'd8,  1'b1, 8'hA5},
            '{1'b0, 48'h0, 32'h0, OP_INIT,   32'h0000_0000, 8'h00, 4'd0,  1'b1, 8'h00},
            '{1'b0, 48'h0, 32'h0, OP_INIT,   32'hFFFF_FFFF, 8'hFF, 4'd15, 1'b1, 8'h00},
            '{1'b0, 48'h0, 32'h0, OP_XCRYPT, 32'h0000_0000, 8'h00, 4'd8,  1'b0, 8'h00},
            '{1'b0, 48'h0, 32'h0, OP_XCRYPT, 32'hFFFF_FFFF, 8'hFF, 4'd8,  1'b0, 8'h00},
            '{1'b0, 48'h0, 32'h0, OP_XCRYPT, 32'h0000_0000, 8'h5A, 4'd0,  1'b1, 8'h5A},
            '{1'b0, 48'h0, 32'h0, OP_XCRYPT, 32'h0000_0000, 8'h3C, 4'd1,  1'b0, 8'h00},
            '{1'b0, 48'h0, 32'h0, OP_XCRYPT, 32'h0000_0000, 8'hC3, 4'd7,  1'b0, 8'h00},
            '{1'b0, 48'h0, 32'h0, OP_XCRYPT, 32'h0000_0000, 8'h81, 4'd9,  1'b0, 8'h00},
            '{1'b0, 48'h0, 32'h0, OP_XCRYPT, 32'h0000_0000, 8'h7E, 4'd15, 1'b0, 8'h00},
            '{1'b0, 48'h0, 32'h0, OP_NONE,   32'hFFFF_FFFF, 8'hFF, 4'd15, 1'b0, 8'h00},
            '{1'b0, 48'h0, 32'h0, OP_AUTH,   32'h0000_0000, 8'h00, 4'd0,  1'b0, 8'h00},
            '{1'b1, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
              OP_INIT,   32'h0000_0000, 8'h00, 4'd8,  1'b1, 8'h00},
            '{1'b0, 48'h0, 32'h0, OP_AUTH,   32'h0000_0000, 8'h00, 4'd8,  1'b0, 8'h00},
            '{1'b0, 48'h0, 32'h0, OP_XCRYPT, 32'h0000_0000, 8'hA5, 4'd8,  1'b0, 8'h00},
            '{1'b0, 48'h0, 32'h0, OP_INIT,   32'hFFFF_FFFF, 8'h00, 4'd8,  1'b1, 8'h00},
            '{1'b0, 48'h0, 32'h0, OP_XCRYPT, 32'h0000_0000, 8'h00, 4'd4,  1'b0, 8'h00},
            '{1'b0, 48'h0, 32'h0, OP_NONE,   32'h0000_0000, 8'h00, 4'd0,  1'b0, 8'h00},
            '{1'b1, 48'h0123_4567_89AB, 32'h8BAD_F00D,
              OP_INIT,   32'h1234_5678, 8'h00, 4'd8,  1'b1, 8'h00},
            '{1'b0, 48'h0, 32'h0, OP_AUTH,   32'h0000_0000, 8'h00, 4'd8,  1'b0, 8'h00},
            '{1'b0, 48'h0, 32'h0, OP_XCRYPT, 32'h0000_0000, 8'h00, 4'd0,  1'b1, 8'h00}
        };

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, starting from the reset register values.
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row = directed_rows[r];
            if (row.load_cfg)
            begin
                load_registers(row.key, row.serial);
            end
            send_item(row.op, row.iv, row.din, row.cnt, row.fixed, row.want);
        end

        // Random phases, each under its own register setting.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                1: begin pk = 48'hFFFF_FFFF_FFFF; ps = 32'h0000_0000; end
                2: begin pk = 48'h0000_0000_0000; ps = 32'hFFFF_FFFF; end
                default:
                begin
                    pk = {16'($urandom), 32'($urandom)};
                    ps = $urandom;
                end
            endcase
            load_registers(pk, ps);
            quiet = (p == 2);
            send_item(OP_INIT, $urandom, 8'h00, BITS_PER_BYTE, 1'b0, 8'h00);
            taken = 0;
            while (taken < PHASE_ITEMS)
            begin
                // Long receiver hold so that the block backs up into the sender.
                if (p == 1 && taken == 5)
                begin
                    hold_req = 1'b1;
                end
                // Sender pause until the pipeline is empty.
                if (p == 3 && taken == 15)
                begin
                    drain_results();
                    next_gap = 0;
                end
                send_random();
                if (operation != OP_NONE)
                begin
                    taken++;
                end
            end
        end
        quiet = 1'b0;

        // Let everything expected arrive, then give stray bytes a chance to show.
        drain_results();
        repeat (DRAIN_LIMIT) @(posedge clk);
        if (pending_bytes.size() != 0)
        begin
            mismatch_count += pending_bytes.size();
            $display("%0t: %0d expected bytes never arrived", $realtime, pending_bytes.size());
        end

        $display("Ran %0d inits, %0d authenticates, %0d transcrypts and %0d dropped codes.",
                 init_count, auth_count, xcrypt_count, ignored_count);
        $display("Checked %0d output bytes over %0d register writes.", result_count, cfg_writes);
        if (mismatch_count == 0)
        begin
            $display("hitag2_stream_cipher test passed");
        end
        else
        begin
            $display("hitag2_stream_cipher test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/ht2_pkg.sv
design/ht2_datapath.sv
design/ht2_ctrl.sv
design/hitag2_stream_cipher.sv
tb/testbench.sv
